// File: rtl/core/mnst_pkg.sv
// ----------------------------------------------------------------------------
// mnst_pkg: shared definitions for the midi note state tracker
// operation and message codes, register indexes, sequencer states and the
// command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package mnst_pkg;

  // sizing defaults and limits
  localparam int NUM_NOTES_DEF  = 128;
  localparam int TIME_BITS_DEF  = 64;
  localparam int PORT_TIME_BITS = 64;
  localparam int MAX_NOTES      = 128;

  // extremes search tree: 16 groups of 8 keys, split in two halves
  localparam int GROUP_SIZE  = 8;
  localparam int GROUP_BITS  = 3;
  localparam int NUM_GROUPS  = 16;
  localparam int HALF_GROUPS = 8;

  // operation codes
  localparam logic [1:0] OP_APPLY = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // status byte high nibble
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;

  // configuration register indexes
  localparam logic CFG_THRESHOLD  = 1'b0;
  localparam logic CFG_CONTROLLER = 1'b1;

  localparam logic [6:0] THRESHOLD_RST  = 7'd64;
  localparam logic [6:0] CONTROLLER_RST = 7'd64;

  // reported when no key is pressed (-1)
  localparam logic [7:0] NONE_HELD = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/mnst_ctrl.sv
// ----------------------------------------------------------------------------
// mnst_ctrl: request sequencer
// steps each request through capture, table update, scan and result load
// ----------------------------------------------------------------------------
module mnst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mnst_pkg::status_t status,
  output mnst_pkg::cmd_t    cmd
);

  mnst_pkg::state_t state;
  mnst_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      mnst_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = mnst_pkg::ST_APPLY;
        end
      end
      mnst_pkg::ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = mnst_pkg::ST_SCAN;
      end
      mnst_pkg::ST_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = mnst_pkg::ST_EMIT;
      end
      mnst_pkg::ST_EMIT: begin
        // wait for the result register to free up
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = mnst_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign in_stall = (state != mnst_pkg::ST_IDLE);

endmodule

// File: rtl/core/mnst_extremes.sv
// ----------------------------------------------------------------------------
// mnst_extremes: lowest and highest pressed key
// registered first level over groups of eight keys, second level over groups
// ----------------------------------------------------------------------------
module mnst_extremes #(
  parameter int NUM_NOTES = mnst_pkg::NUM_NOTES_DEF
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic [NUM_NOTES-1:0] held,
  output logic [7:0]           lowest,
  output logic [7:0]           highest
);

  localparam int PAD_BITS = mnst_pkg::MAX_NOTES;
  localparam int GS       = mnst_pkg::GROUP_SIZE;
  localparam int GB       = mnst_pkg::GROUP_BITS;
  localparam int NG       = mnst_pkg::NUM_GROUPS;
  localparam int HG       = mnst_pkg::HALF_GROUPS;

  logic [PAD_BITS-1:0] pad;
  logic [NG-1:0]       grp_any_c;
  logic [GB-1:0]       grp_lo_c [NG];
  logic [GB-1:0]       grp_hi_c [NG];
  logic [NG-1:0]       grp_any;
  logic [GB-1:0]       grp_lo [NG];
  logic [GB-1:0]       grp_hi [NG];
  logic [1:0]          found_lo;
  logic [1:0]          found_hi;
  logic [6:0]          lo_idx [2];
  logic [6:0]          hi_idx [2];

  assign pad = PAD_BITS'(held);

  // per-group priority, eight steps each
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_c[g] = |pad[g*GS +: GS];
      grp_lo_c[g]  = '0;
      grp_hi_c[g]  = '0;
      for (int b = GS - 1; b >= 0; b--) begin
        if (pad[g*GS + b]) grp_lo_c[g] = GB'(b);
      end
      for (int b = 0; b < GS; b++) begin
        if (pad[g*GS + b]) grp_hi_c[g] = GB'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_any <= grp_any_c;
      for (int g = 0; g < NG; g++) begin
        grp_lo[g] <= grp_lo_c[g];
        grp_hi[g] <= grp_hi_c[g];
      end
    end
  end

  // second level: each half of eight groups on its own, then pick
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      found_lo[h] = 1'b0;
      found_hi[h] = 1'b0;
      lo_idx[h]   = '0;
      hi_idx[h]   = '0;
      for (int j = HG - 1; j >= 0; j--) begin
        if (grp_any[h*HG + j]) begin
          found_lo[h] = 1'b1;
          lo_idx[h]   = {1'(h), 3'(j), grp_lo[h*HG + j]};
        end
      end
      for (int j = 0; j < HG; j++) begin
        if (grp_any[h*HG + j]) begin
          found_hi[h] = 1'b1;
          hi_idx[h]   = {1'(h), 3'(j), grp_hi[h*HG + j]};
        end
      end
    end
  end

  always_comb begin
    priority if (found_lo[0]) begin
      lowest = {1'b0, lo_idx[0]};
    end else if (found_lo[1]) begin
      lowest = {1'b0, lo_idx[1]};
    end else begin
      lowest = mnst_pkg::NONE_HELD;
    end
    priority if (found_hi[1]) begin
      highest = {1'b0, hi_idx[1]};
    end else if (found_hi[0]) begin
      highest = {1'b0, hi_idx[0]};
    end else begin
      highest = mnst_pkg::NONE_HELD;
    end
  end

endmodule

// File: rtl/core/mnst_dpath.sv
// ----------------------------------------------------------------------------
// mnst_dpath: note table datapath
// key and pedal flags, press memory, running counts, pedal and registers,
// and the result register
// ----------------------------------------------------------------------------
module mnst_dpath #(
  parameter int NUM_NOTES = mnst_pkg::NUM_NOTES_DEF,
  parameter int TIME_BITS = mnst_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mnst_pkg::cmd_t                      cmd,
  output mnst_pkg::status_t                   status,
  // configuration
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [6:0]                          cfg_data,
  // request
  input  logic [1:0]                          operation,
  input  logic [7:0]                          status_byte,
  input  logic [6:0]                          data_one,
  input  logic [6:0]                          data_two,
  input  logic [mnst_pkg::PORT_TIME_BITS-1:0] timestamp,
  input  logic [6:0]                          query_pitch,
  // result
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                key_held,
  output logic                                sounding,
  output logic                                pedal_only,
  output logic [6:0]                          note_velocity,
  output logic [mnst_pkg::PORT_TIME_BITS-1:0] press_time,
  output logic [7:0]                          held_count,
  output logic [7:0]                          sounding_count,
  output logic [7:0]                          lowest_held,
  output logic [7:0]                          highest_held,
  output logic                                pedal_down
);

  localparam int IDX_BITS = (NUM_NOTES > 1) ? $clog2(NUM_NOTES) : 1;
  localparam int CNT_BITS = $clog2(NUM_NOTES + 1);
  localparam logic [7:0] NOTE_LIMIT = 8'(NUM_NOTES);

  typedef struct packed {
    logic [6:0]           vel;
    logic [TIME_BITS-1:0] stamp;
  } entry_t;

  // captured request
  logic [1:0]           op_q;
  logic [3:0]           kind_q;
  logic [6:0]           d1_q;
  logic [6:0]           d2_q;
  logic [TIME_BITS-1:0] ts_q;
  logic [6:0]           q_q;

  // table state
  logic [NUM_NOTES-1:0] key_flags;
  logic [NUM_NOTES-1:0] pedal_flags;
  logic [NUM_NOTES-1:0] entry_valid;
  entry_t               mem [NUM_NOTES];
  logic [6:0]           pedal_value;
  logic [CNT_BITS-1:0]  held_total;
  logic [CNT_BITS-1:0]  pedal_total;
  logic [6:0]           threshold;
  logic [6:0]           controller;

  // query read-out
  entry_t               rd_entry;
  logic                 rd_ok;
  logic                 q_key;
  logic                 q_ped;

  logic [IDX_BITS-1:0]  idx;
  logic [IDX_BITS-1:0]  q_idx;
  logic                 note_ok;
  logic                 q_ok;
  logic                 op_apply;
  logic                 op_clear;
  logic                 do_press;
  logic                 do_release;
  logic                 do_pedal;
  logic                 pedal_dn;
  logic                 pedal_dn_new;
  logic [7:0]           lowest_c;
  logic [7:0]           highest_c;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      kind_q <= status_byte[7:4];
      d1_q   <= data_one;
      d2_q   <= data_two;
      ts_q   <= timestamp[TIME_BITS-1:0];
      q_q    <= query_pitch;
    end
  end

  assign idx      = d1_q[IDX_BITS-1:0];
  assign q_idx    = q_q[IDX_BITS-1:0];
  assign note_ok  = ({1'b0, d1_q} < NOTE_LIMIT);
  assign q_ok     = ({1'b0, q_q} < NOTE_LIMIT);
  assign op_apply = (op_q == mnst_pkg::OP_APPLY);
  assign op_clear = (op_q == mnst_pkg::OP_CLEAR);

  assign pedal_dn     = (pedal_value >= threshold);
  assign pedal_dn_new = (d2_q >= threshold);

  assign do_press   = op_apply && note_ok && (kind_q == mnst_pkg::KIND_NOTE_ON) &&
                      (d2_q != 7'd0);
  assign do_release = op_apply && note_ok && key_flags[idx] &&
                      ((kind_q == mnst_pkg::KIND_NOTE_OFF) ||
                       ((kind_q == mnst_pkg::KIND_NOTE_ON) && (d2_q == 7'd0)));
  assign do_pedal   = op_apply && (kind_q == mnst_pkg::KIND_CTRL) && (d1_q == controller);

  // flags, counts, pedal and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_flags   <= '0;
      pedal_flags <= '0;
      entry_valid <= '0;
      pedal_value <= '0;
      held_total  <= '0;
      pedal_total <= '0;
      threshold   <= mnst_pkg::THRESHOLD_RST;
      controller  <= mnst_pkg::CONTROLLER_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mnst_pkg::CFG_THRESHOLD:  threshold  <= cfg_data;
          mnst_pkg::CFG_CONTROLLER: controller <= cfg_data;
        endcase
      end
      // queries and ignored messages fall through every branch
      if (cmd.apply) begin
        if (op_clear) begin
          key_flags   <= '0;
          pedal_flags <= '0;
          entry_valid <= '0;
          pedal_value <= '0;
          held_total  <= '0;
          pedal_total <= '0;
        end else if (do_press) begin
          key_flags[idx]   <= 1'b1;
          pedal_flags[idx] <= 1'b0;
          entry_valid[idx] <= 1'b1;
          if (!key_flags[idx]) held_total <= held_total + CNT_BITS'(1);
          // a pedal-held note taken back by its key
          if (pedal_flags[idx]) pedal_total <= pedal_total - CNT_BITS'(1);
        end else if (do_release) begin
          key_flags[idx] <= 1'b0;
          held_total     <= held_total - CNT_BITS'(1);
          if (pedal_dn) begin
            pedal_flags[idx] <= 1'b1;
            pedal_total      <= pedal_total + CNT_BITS'(1);
          end
        end else if (do_pedal) begin
          pedal_value <= d2_q;
          if (pedal_dn && !pedal_dn_new) begin
            pedal_flags <= '0;
            pedal_total <= '0;
          end
        end
      end
    end
  end

  // press memory: written on update, read for the query in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.apply && !op_clear && do_press) begin
      mem[idx] <= '{vel: d2_q, stamp: ts_q};
    end
    if (cmd.scan) begin
      rd_entry <= mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_ok <= q_ok && entry_valid[q_idx];
      q_key <= q_ok && key_flags[q_idx];
      q_ped <= q_ok && pedal_flags[q_idx];
    end
  end

  mnst_extremes #(
    .NUM_NOTES(NUM_NOTES)
  ) u_extremes (
    .clk    (clk),
    .load   (cmd.scan),
    .held   (key_flags),
    .lowest (lowest_c),
    .highest(highest_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      key_held       <= q_key;
      sounding       <= q_key | q_ped;
      pedal_only     <= q_ped & ~q_key;
      note_velocity  <= rd_ok ? rd_entry.vel : 7'd0;
      press_time     <= rd_ok ? mnst_pkg::PORT_TIME_BITS'(rd_entry.stamp) : '0;
      held_count     <= 8'(held_total);
      sounding_count <= 8'(held_total + pedal_total);
      lowest_held    <= lowest_c;
      highest_held   <= highest_c;
      pedal_down     <= pedal_dn;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule

// File: rtl/core/midi_note_state_tracker.sv
// ----------------------------------------------------------------------------
// midi_note_state_tracker: per-note key and sustain pedal state table
// applies midi note and pedal messages and reports a note's state with
// table-wide summaries
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one request per midi message, query or
//   clear; taken when in_valid is high and in_stall low.
//   output channel (out_valid / out_stall): exactly one result per request, in
//   order; a result sits in the output register until out_stall is low.
//   config channel (cfg_valid / cfg_ready): cfg_index 0 is the sustain
//   threshold, 1 the sustain controller number; always ready. write only
//   while no request is in flight.
// sequence
//   a request is captured, applied to the table, scanned and loaded into the
//   output register by the capture / update / memory read / load sequence of
//   the controller; a new request is taken only once the controller is back in
//   idle, and the next request is taken while the previous result still waits
//   at the output.
// reset and stall
//   rst clears the table, counts and pedal and loads the register defaults.
//   if the receiver stalls, the finished result holds and the sequencer waits
//   in its load step with in_stall high.
// ----------------------------------------------------------------------------
module midi_note_state_tracker #(
  parameter int NUM_NOTES = mnst_pkg::NUM_NOTES_DEF,
  parameter int TIME_BITS = mnst_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [6:0]                          cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          operation,
  input  logic [7:0]                          status_byte,
  input  logic [6:0]                          data_one,
  input  logic [6:0]                          data_two,
  input  logic [mnst_pkg::PORT_TIME_BITS-1:0] timestamp,
  input  logic [6:0]                          query_pitch,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                key_held,
  output logic                                sounding,
  output logic                                pedal_only,
  output logic [6:0]                          note_velocity,
  output logic [mnst_pkg::PORT_TIME_BITS-1:0] press_time,
  output logic [7:0]                          held_count,
  output logic [7:0]                          sounding_count,
  output logic signed [7:0]                   lowest_held,
  output logic signed [7:0]                   highest_held,
  output logic                                pedal_down
);

  mnst_pkg::cmd_t    cmd;
  mnst_pkg::status_t status;

  // registers are plain flops, a write always lands
  assign cfg_ready = 1'b1;

  // sequencer: one request at a time
  mnst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  // table, counts, extremes search and result register
  mnst_dpath #(
    .NUM_NOTES(NUM_NOTES),
    .TIME_BITS(TIME_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .status_byte   (status_byte),
    .data_one      (data_one),
    .data_two      (data_two),
    .timestamp     (timestamp),
    .query_pitch   (query_pitch),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .key_held      (key_held),
    .sounding      (sounding),
    .pedal_only    (pedal_only),
    .note_velocity (note_velocity),
    .press_time    (press_time),
    .held_count    (held_count),
    .sounding_count(sounding_count),
    .lowest_held   (lowest_held),
    .highest_held  (highest_held),
    .pedal_down    (pedal_down)
  );

endmodule

// File: rtl/core/mnst_checker.sv
// ----------------------------------------------------------------------------
// mnst_checker: port-level checks for the note state tracker
// result consistency and output hold under stall, bound to the top level
// ----------------------------------------------------------------------------
module mnst_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                key_held,
  input logic                                sounding,
  input logic                                pedal_only,
  input logic [6:0]                          note_velocity,
  input logic [mnst_pkg::PORT_TIME_BITS-1:0] press_time,
  input logic [7:0]                          held_count,
  input logic [7:0]                          sounding_count,
  input logic [7:0]                          lowest_held,
  input logic [7:0]                          highest_held
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(key_held) &&
      $stable(note_velocity) && $stable(press_time) && $stable(held_count) &&
      $stable(sounding_count) && $stable(lowest_held) && $stable(highest_held)))
    else $error("result changed while stalled");

  // reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("state after reset wrong");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (held_count <= sounding_count))
    else $error("held count above sounding count");

  a_extremes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((held_count == 8'd0) == (lowest_held == mnst_pkg::NONE_HELD)) &&
                   ((held_count == 8'd0) == (highest_held == mnst_pkg::NONE_HELD)) &&
                   (lowest_held <= highest_held)))
    else $error("key extremes disagree with held count");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pedal_only) |-> (sounding && !key_held))
    else $error("pedal-only note not sounding or key held");

endmodule

bind midi_note_state_tracker mnst_checker u_checker (.*);
